>>> hw/rtl/u64dd_pkg.sv
// Package for the 64-bit binary to decimal digit converter.
// Holds the shared widths, codes and the status struct; no dependencies.
`timescale 1ns / 1ps

package u64dd_pkg;

  localparam int unsigned BinW     = 64;
  localparam int unsigned NumDigits = 20;
  localparam int unsigned BcdW     = 4 * NumDigits;
  localparam int unsigned StepW    = $clog2(BinW + 1);
  localparam int unsigned DigCntW  = $clog2(NumDigits + 1);
  localparam int unsigned CharW    = 6;

  // Character code of the digit zero, trimmed to the output width.
  localparam logic [CharW-1:0] CHAR_ZERO = 6'd48;

  typedef struct packed {
    logic busy;
    logic done;
  } dd_status_t;

endpackage

>>> hw/rtl/u64dd_dabble.sv
// Iterative shift-and-add-3 converter from a 64-bit binary word to 20 BCD digits.
// Depends on u64dd_pkg for widths and the status struct.
`timescale 1ns / 1ps

module u64dd_dabble import u64dd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [BinW-1:0]    value,
  output dd_status_t         status,
  output logic [BcdW-1:0]    bcd
);

  logic [BinW-1:0]  bin_r, bin_nxt;
  logic [BcdW-1:0]  bcd_r, bcd_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BcdW-1:0]  adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = StepW'(BinW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BcdW-2:0], bin_r[BinW-1]};
      bin_nxt = {bin_r[BinW-2:0], 1'b0};
      cnt_nxt = cnt_r - StepW'(1);
      if (cnt_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign bcd         = bcd_r;

endmodule

>>> hw/rtl/uint64_to_decimal_digits.sv
// Top level of the 64-bit unsigned to decimal digit converter.
// Depends on u64dd_pkg and instantiates u64dd_dabble.
`timescale 1ns / 1ps

// One request carries a 64-bit unsigned value; the block answers with one
// result request per decimal digit, most significant first, without leading
// zeros (zero gives a single '0'), each digit as its character code 48..57 and
// with out_is_last set on the final digit. The block works on one value at a
// time: in_stall is high from the accepting edge until the last digit has been
// taken. A value passes through the shift-and-add-3 converter (one input
// bit per cycle), hands its 20 BCD digits to the output shifter, then
// drops the skipped leading zeros one per cycle and holds each digit shown
// until the receiver takes it, so with no output stall the time a value
// takes does not depend on its digit count. The converter's single add-3
// row and the output shift register set the time per value.

module uint64_to_decimal_digits import u64dd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BinW-1:0]   in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CharW-1:0]  out_digit_char,
  output logic              out_is_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [BcdW-1:0]    dig_r, dig_nxt;
  logic [DigCntW-1:0] left_r, left_nxt;
  logic               started_r, started_nxt;

  logic               in_acc;
  dd_status_t         conv_status;
  logic [BcdW-1:0]    conv_bcd;
  logic [3:0]         top_dig;
  logic               last_pos;
  logic               show;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  u64dd_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .value  (in_value),
    .status (conv_status),
    .bcd    (conv_bcd)
  );

  // The digit being looked at is always the top nibble of the shifter.
  // A digit is shown once any nonzero digit has been seen, or when it is
  // the units digit, so that zero still produces one '0'.
  assign top_dig  = dig_r[BcdW-1 -: 4];
  assign last_pos = (left_r == DigCntW'(1));
  assign show     = started_r || (top_dig != 4'd0) || last_pos;

  assign out_valid      = (state_r == ST_EMIT) && show;
  assign out_digit_char = CHAR_ZERO | {2'b00, top_dig};
  assign out_is_last    = last_pos;

  always_comb begin
    state_nxt   = state_r;
    dig_nxt     = dig_r;
    left_nxt    = left_r;
    started_nxt = started_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_status.done) begin
          dig_nxt     = conv_bcd;
          left_nxt    = DigCntW'(NumDigits);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Leading zeros drop out one per cycle; a shown digit moves on
        // only when the receiver takes it.
        if (!show || !out_stall) begin
          dig_nxt  = {dig_r[BcdW-5:0], 4'd0};
          left_nxt = left_r - DigCntW'(1);
          if (show) begin
            started_nxt = 1'b1;
            if (last_pos) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    left_r <= left_nxt;
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
  end

endmodule
